[design/iair_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iair_pkg: shared types and constants of the indexed list
// Sizes, request and status codes and the result bundle passed to the top.
// ----------------------------------------------------------------------------
package iair_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 2;
    localparam int ECNT_W  = 5;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [MODE_W-1:0] {
        MD_INSERT   = 3'd0,
        MD_REMOVE   = 3'd1,
        MD_READ     = 3'd2,
        MD_WRITE    = 3'd3,
        MD_CONTAINS = 3'd4
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // one access to the entry store
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    // finished request
    typedef struct packed {
        logic [DATA_W-1:0] rd;
        logic              found;
        t_status           status;
        logic [CNT_W-1:0]  count;
    } t_result;

endpackage

[design/iair_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iair_mem: entry store of the indexed list
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iair_mem (
    input  logic                        i_clk,
    input  iair_pkg::t_mem_req          i_req,
    output logic [iair_pkg::DATA_W-1:0] o_rdata
);
    import iair_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write and registered read; contents undefined until written
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/iair_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iair_ctrl: request sequencer of the indexed list
// Walks the store one entry at a time with a shared index stepper to shift,
// fetch and scan, and keeps the live entry count.
// ----------------------------------------------------------------------------
module iair_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [iair_pkg::MODE_W-1:0] i_mode,
    input  logic [iair_pkg::POS_W-1:0]  i_pos,
    input  logic [iair_pkg::DATA_W-1:0] i_val,
    input  logic [iair_pkg::DATA_W-1:0] i_rdata,
    output iair_pkg::t_mem_req          o_req,
    output logic                        o_busy,
    output logic                        o_done,
    output iair_pkg::t_result           o_res
);
    import iair_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_WR,
        S_REM_CAP,
        S_REM,
        S_REM_WR,
        S_RD_CAP,
        S_SCAN
    } t_state;

    t_state            r_state;
    logic              r_cmp;      // scan: compare fetched word next cycle
    logic [IDX_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_val;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    t_result           r_res;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              full;
    logic              pos_lt_cnt;
    logic              pos_le_cnt;
    logic              start_ok;
    logic              dec;
    logic [CNT_W-1:0]  step;
    logic              at_pos;

    // request checks against the live count
    assign pos_ext    = CMP_W'(i_pos);
    assign cnt_ext    = CMP_W'(r_cnt);
    assign full       = (r_cnt >= CNT_W'(DEPTH));
    assign pos_lt_cnt = (pos_ext < cnt_ext);
    assign pos_le_cnt = (pos_ext <= cnt_ext);
    assign start_ok   = i_start && (r_state == S_IDLE);

    // shared index stepper: down while inserting, up otherwise
    assign dec    = (r_state == S_INS) || (r_state == S_INS_WR);
    assign step   = dec ? (r_idx - CNT_W'(1)) : (r_idx + CNT_W'(1));
    assign at_pos = (r_idx == CNT_W'(r_pos));

    // drive the store for the current step
    always_comb begin
        o_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start_ok && pos_lt_cnt) begin
                    if (i_mode == MD_REMOVE || i_mode == MD_READ) begin
                        o_req.re    = 1'b1;
                        o_req.raddr = IDX_W'(i_pos);
                    end
                    if (i_mode == MD_WRITE) begin
                        o_req.we    = 1'b1;
                        o_req.waddr = IDX_W'(i_pos);
                        o_req.wdata = i_val;
                    end
                end
            end
            S_INS: begin
                if (at_pos) begin
                    o_req.we    = 1'b1;
                    o_req.waddr = r_pos;
                    o_req.wdata = r_val;
                end else begin
                    o_req.re    = 1'b1;
                    o_req.raddr = step[IDX_W-1:0];
                end
            end
            S_INS_WR: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_idx[IDX_W-1:0];
                o_req.wdata = i_rdata;
            end
            S_REM: begin
                if (step < r_cnt) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = step[IDX_W-1:0];
                end
            end
            S_REM_WR: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_idx[IDX_W-1:0];
                o_req.wdata = i_rdata;
            end
            S_SCAN: begin
                if (!r_cmp && r_idx < r_cnt) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = r_idx[IDX_W-1:0];
                end
            end
            default: begin
                o_req = '0;
            end
        endcase
    end

    // sequence requests, hold count and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_cmp   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start_ok) begin
                        r_val        <= i_val;
                        r_pos        <= IDX_W'(i_pos);
                        r_cmp        <= 1'b0;
                        r_res.rd     <= '0;
                        r_res.found  <= 1'b0;
                        r_res.status <= ST_OK;
                        r_res.count  <= r_cnt;
                        unique case (i_mode)
                            MD_INSERT: begin
                                if (full) begin
                                    r_res.status <= ST_FULL;
                                    r_done       <= 1'b1;
                                end else if (!pos_le_cnt) begin
                                    r_res.status <= ST_RANGE;
                                    r_done       <= 1'b1;
                                end else begin
                                    r_idx   <= r_cnt;
                                    r_state <= S_INS;
                                end
                            end
                            MD_REMOVE: begin
                                if (!pos_lt_cnt) begin
                                    r_res.status <= ST_RANGE;
                                    r_done       <= 1'b1;
                                end else begin
                                    r_idx   <= CNT_W'(i_pos);
                                    r_state <= S_REM_CAP;
                                end
                            end
                            MD_READ: begin
                                if (!pos_lt_cnt) begin
                                    r_res.status <= ST_RANGE;
                                    r_done       <= 1'b1;
                                end else begin
                                    r_state <= S_RD_CAP;
                                end
                            end
                            MD_WRITE: begin
                                if (!pos_lt_cnt) begin
                                    r_res.status <= ST_RANGE;
                                end
                                r_done <= 1'b1;
                            end
                            MD_CONTAINS: begin
                                r_idx   <= '0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_INS: begin
                    if (at_pos) begin
                        r_cnt       <= r_cnt + CNT_W'(1);
                        r_res.count <= r_cnt + CNT_W'(1);
                        r_done      <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    r_idx   <= step;
                    r_state <= S_INS;
                end
                S_REM_CAP: begin
                    r_res.rd <= i_rdata;
                    r_state  <= S_REM;
                end
                S_REM: begin
                    if (step < r_cnt) begin
                        r_state <= S_REM_WR;
                    end else begin
                        r_cnt       <= r_cnt - CNT_W'(1);
                        r_res.count <= r_cnt - CNT_W'(1);
                        r_done      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_REM_WR: begin
                    r_idx   <= step;
                    r_state <= S_REM;
                end
                S_RD_CAP: begin
                    r_res.rd <= i_rdata;
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_cmp) begin
                        r_cmp <= 1'b0;
                        if (i_rdata == r_val) begin
                            r_res.found <= 1'b1;
                            r_done      <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_idx <= step;
                        end
                    end else if (r_idx < r_cnt) begin
                        r_cmp <= 1'b1;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[design/indexed_array_insert_remove.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_insert_remove: ordered list with insert and remove by index
// Keeps up to DEPTH words in order plus a live count; serves insert, remove,
// read, write and contains requests one at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with mode, position and item_value while busy is low; the
//   word is taken at that clock edge. Busy stays high while the request runs.
//   Exactly one result word follows: o_valid is high for one cycle with
//   o_read_value, o_found, o_status and o_entry_count. The receiver cannot
//   stall, so it must take the word in that cycle.
//   Write, failed checks and unused modes answer straight from idle; read
//   first captures the fetched word. Insert, remove and contains walk the
//   store one entry at a time: each shifted entry is read and then written
//   back, each scanned entry is read and then compared, and contains stops
//   at the first hit.
//   A new request may start in the cycle o_valid is high.
//   Reset (synchronous, active low) empties the list; entry contents are not
//   cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module indexed_array_insert_remove (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [iair_pkg::MODE_W-1:0] i_mode,
    input  logic [iair_pkg::POS_W-1:0]  i_position,
    input  logic [iair_pkg::VAL_W-1:0]  i_item_value,
    output logic                        o_valid,
    output logic [iair_pkg::VAL_W-1:0]  o_read_value,
    output logic                        o_found,
    output logic [iair_pkg::STAT_W-1:0] o_status,
    output logic [iair_pkg::ECNT_W-1:0] o_entry_count
);
    import iair_pkg::*;

    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    logic [DATA_W-1:0] in_val;
    t_result           res;

    // mask the incoming value to the stored width
    assign in_val = DATA_W'(i_item_value);

    iair_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_mode),
        .i_pos   (i_position),
        .i_val   (in_val),
        .i_rdata (mem_rdata),
        .o_req   (mem_req),
        .o_busy  (busy),
        .o_done  (o_valid),
        .o_res   (res)
    );

    iair_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // map the result word to the ports
    assign o_read_value  = VAL_W'(res.rd);
    assign o_found       = res.found;
    assign o_status      = res.status;
    assign o_entry_count = ECNT_W'(res.count);

    // a result only appears with the sequencer back at rest
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word while sequencer busy");

    // every accepted word either runs or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted word dropped");

    // live count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (res.count <= CNT_W'(DEPTH)))
        else $error("live count above capacity");

    // a found flag only comes with an ok status and no data
    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (res.status == ST_OK && res.rd == '0))
        else $error("found flag with bad status or data");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the indexed list
// Drives insert, remove, read, write, contains and unused-mode requests
// through the start/busy handshake. A local model of the list predicts every
// result word, and a monitor checks each strobed word field by field. A short
// table of directed requests comes first. Random phases follow that grow the
// list to full, shrink it to empty and mix both, with idle gaps on the
// request side.
// ----------------------------------------------------------------------------
module tb_top;
    import iair_pkg::*;

    // unused request codes: the block must answer them and change nothing
    localparam logic [MODE_W-1:0] MD_SPARE5 = 3'd5;
    localparam logic [MODE_W-1:0] MD_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MD_SPARE7 = 3'd7;

    localparam int RAND_PHASES    = 10;
    localparam int ITEMS_PER_PH   = 90;
    localparam int QUIET_CYCLES   = 40;

    typedef struct packed {
        logic [VAL_W-1:0]  rd;
        logic              found;
        t_status           status;
        logic [ECNT_W-1:0] count;
    } t_list_reply;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        logic              typed;
        t_list_reply       want;
    } t_list_step;

    localparam t_list_reply NO_REPLY = '{32'h0, 1'b0, ST_OK, 5'd0};

    // directed requests; rows with typed set carry a hand-written answer
    localparam int DIR_N = 25;
    localparam t_list_step DIR_TAB [DIR_N] = '{
        '{MD_READ,     5'd0,  32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_RANGE, 5'd0}},
        '{MD_REMOVE,   5'd0,  32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_RANGE, 5'd0}},
        '{MD_WRITE,    5'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, ST_RANGE, 5'd0}},
        '{MD_CONTAINS, 5'd0,  32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_OK,    5'd0}},
        '{MD_INSERT,   5'd1,  32'h1234_5678, 1'b1, '{32'h0, 1'b0, ST_RANGE, 5'd0}},
        '{MD_INSERT,   5'd31, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, ST_RANGE, 5'd0}},
        '{MD_INSERT,   5'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, ST_OK,    5'd1}},
        '{MD_INSERT,   5'd0,  32'h0000_0000, 1'b0, NO_REPLY},
        '{MD_INSERT,   5'd2,  32'h8000_0000, 1'b0, NO_REPLY},
        '{MD_INSERT,   5'd1,  32'h0000_0001, 1'b0, NO_REPLY},
        '{MD_READ,     5'd0,  32'hDEAD_BEEF, 1'b0, NO_REPLY},
        '{MD_READ,     5'd3,  32'h0000_0000, 1'b0, NO_REPLY},
        '{MD_READ,     5'd4,  32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_RANGE, 5'd4}},
        '{MD_CONTAINS, 5'd31, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
        '{MD_CONTAINS, 5'd0,  32'h1234_5678, 1'b0, NO_REPLY},
        '{MD_WRITE,    5'd3,  32'h7FFF_FFFF, 1'b0, NO_REPLY},
        '{MD_WRITE,    5'd31, 32'h5A5A_5A5A, 1'b1, '{32'h0, 1'b0, ST_RANGE, 5'd4}},
        '{MD_REMOVE,   5'd31, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_RANGE, 5'd4}},
        '{MD_REMOVE,   5'd1,  32'hFFFF_FFFF, 1'b0, NO_REPLY},
        '{MD_REMOVE,   5'd2,  32'h0000_0000, 1'b0, NO_REPLY},
        '{MD_SPARE5,   5'd31, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
        '{MD_SPARE6,   5'd0,  32'hA5A5_A5A5, 1'b0, NO_REPLY},
        '{MD_SPARE7,   5'd0,  32'h0000_0000, 1'b0, NO_REPLY},
        '{MD_CONTAINS, 5'd0,  32'h7FFF_FFFF, 1'b0, NO_REPLY},
        '{MD_REMOVE,   5'd0,  32'h0000_0000, 1'b0, NO_REPLY}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [MODE_W-1:0]  i_mode;
    logic [POS_W-1:0]   i_position;
    logic [VAL_W-1:0]   i_item_value;
    logic               o_valid;
    logic [VAL_W-1:0]   o_read_value;
    logic               o_found;
    logic [STAT_W-1:0]  o_status;
    logic [ECNT_W-1:0]  o_entry_count;

    // local copy of the list
    logic [VAL_W-1:0]   list_mem [DEPTH];
    int                 live_n;

    t_list_reply        reply_q [$];
    bit                 idle_on;
    int                 n_errors;
    int                 n_words;
    int                 n_sent;
    int                 n_full;
    int                 n_range;
    int                 n_hits;

    indexed_array_insert_remove uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_found       (o_found),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // apply one request to the local list and return the word it yields
    function automatic t_list_reply apply_request(input logic [MODE_W-1:0] mode,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [VAL_W-1:0] val);
        t_list_reply r;
        int          p;
        int          i;
        r = NO_REPLY;
        p = int'(pos);
        case (mode)
            MD_INSERT: begin
                if (live_n >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else if (p > live_n) begin
                    r.status = ST_RANGE;
                    n_range++;
                end else begin
                    for (i = live_n; i > p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p] = val;
                    live_n++;
                end
            end
            MD_REMOVE: begin
                if (p >= live_n) begin
                    r.status = ST_RANGE;
                    n_range++;
                end else begin
                    r.rd = list_mem[p];
                    for (i = p + 1; i < live_n; i++)
                        list_mem[i-1] = list_mem[i];
                    live_n--;
                end
            end
            MD_READ: begin
                if (p >= live_n) begin
                    r.status = ST_RANGE;
                    n_range++;
                end else begin
                    r.rd = list_mem[p];
                end
            end
            MD_WRITE: begin
                if (p >= live_n) begin
                    r.status = ST_RANGE;
                    n_range++;
                end else begin
                    list_mem[p] = val;
                end
            end
            MD_CONTAINS: begin
                for (i = 0; i < live_n; i++) begin
                    if (list_mem[i] == val)
                        r.found = 1'b1;
                end
                if (r.found)
                    n_hits++;
            end
            default: begin
            end
        endcase
        r.count = live_n[ECNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("%0t ns: mismatch on %s: got %h, want %h", $time, field, got, want);
        n_errors++;
    endtask

    // present one word, wait for its handshake, then queue its answer
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val, input logic typed,
                             input t_list_reply typed_reply);
        t_list_reply pred;
        if (idle_on && $urandom_range(0, 99) < 9) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < 9)
                @(posedge i_clk);
        end
        start        <= 1'b1;
        i_mode       <= mode;
        i_position   <= pos;
        i_item_value <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = apply_request(mode, pos, val);
        reply_q.push_back(typed ? typed_reply : pred);
        n_sent++;
    endtask

    // hold start low until every queued answer has come back
    task automatic wait_quiet();
        start <= 1'b0;
        do @(posedge i_clk); while (reply_q.size() != 0);
    endtask

    // check each strobed word against the oldest expectation
    always @(posedge i_clk) begin : chk_words
        t_list_reply want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (reply_q.size() == 0) begin
                report_mismatch("unexpected word", o_read_value, '0);
            end else begin
                want = reply_q.pop_front();
                if (o_read_value !== want.rd)
                    report_mismatch("read_value", o_read_value, want.rd);
                if (o_found !== want.found)
                    report_mismatch("found", 32'(o_found), 32'(want.found));
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", 32'(o_entry_count), 32'(want.count));
                n_words++;
            end
        end
    end

    // main sequence
    initial begin : run
        int                 k;
        int                 ph;
        int                 r;
        int                 ins_w;
        int                 rem_w;
        logic [MODE_W-1:0]  mode;
        logic [POS_W-1:0]   pos;
        logic [VAL_W-1:0]   val;

        n_errors = 0;
        n_words  = 0;
        n_sent   = 0;
        n_full   = 0;
        n_range  = 0;
        n_hits   = 0;
        live_n   = 0;
        idle_on  = 1'b1;
        for (k = 0; k < DEPTH; k++)
            list_mem[k] = '0;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_mode       <= '0;
        i_position   <= '0;
        i_item_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        for (k = 0; k < DIR_N; k++)
            send_word(DIR_TAB[k].mode, DIR_TAB[k].pos, DIR_TAB[k].val,
                      DIR_TAB[k].typed, DIR_TAB[k].want);
        wait_quiet();

        // random phases: grow to full, shrink to empty, then mixed traffic
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            idle_on = (ph != 4);
            case (ph % 3)
                0:       begin ins_w = 60; rem_w = 8;  end
                1:       begin ins_w = 12; rem_w = 55; end
                default: begin ins_w = 30; rem_w = 25; end
            endcase
            for (k = 0; k < ITEMS_PER_PH; k++) begin
                // pick the request code
                r = $urandom_range(0, 99);
                if (r < ins_w)
                    mode = MD_INSERT;
                else if (r < ins_w + rem_w)
                    mode = MD_REMOVE;
                else if (r < 96) begin
                    case (r % 3)
                        0:       mode = MD_READ;
                        1:       mode = MD_WRITE;
                        default: mode = MD_CONTAINS;
                    endcase
                end else begin
                    mode = MODE_W'($urandom_range(5, 7));
                end

                // mostly legal positions, some anywhere in the field
                if ($urandom_range(0, 99) < 12)
                    pos = POS_W'($urandom_range(0, 31));
                else if (mode == MD_INSERT)
                    pos = POS_W'($urandom_range(0, live_n));
                else if (live_n > 0)
                    pos = POS_W'($urandom_range(0, live_n - 1));
                else
                    pos = POS_W'($urandom_range(0, 31));

                // search for live values half the time; reuse a small pool
                r = $urandom_range(0, 99);
                if (mode == MD_CONTAINS && live_n > 0 && r < 50)
                    val = list_mem[$urandom_range(0, live_n - 1)];
                else if (r < 70) begin
                    case ($urandom_range(0, 4))
                        0:       val = 32'h0000_0000;
                        1:       val = 32'hFFFF_FFFF;
                        2:       val = 32'h8000_0000;
                        3:       val = 32'h0000_0001;
                        default: val = VAL_W'($urandom_range(0, 15));
                    endcase
                end else begin
                    val = $urandom;
                end

                send_word(mode, pos, val, 1'b0, NO_REPLY);
            end
            wait_quiet();
        end

        // let any stray word show up
        repeat (QUIET_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d result words.", n_sent, n_words);
        $display("Saw %0d full-list inserts, %0d out-of-range requests, %0d contains hits.",
                 n_full, n_range, n_hits);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hard stop if the handshake hangs
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
